// File: rtl/u8l9_pkg.sv
// ----------------------------------------------------------------------------
// u8l9_pkg
// Shared types, code points and the Latin-9 mapping for the UTF-8 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package u8l9_pkg;

   localparam int unsigned BYTE_BITS = 8;
   localparam int unsigned LEN_BITS  = 16;
   localparam int unsigned ACC_BITS  = 31;
   localparam int unsigned REM_BITS  = 3;

   // Code points that Latin-9 places in the upper half
   localparam logic [ACC_BITS-1:0] CP_OE_CAP    = 31'h0152;
   localparam logic [ACC_BITS-1:0] CP_OE_SMALL  = 31'h0153;
   localparam logic [ACC_BITS-1:0] CP_S_CARON   = 31'h0160;
   localparam logic [ACC_BITS-1:0] CP_S_CARON_L = 31'h0161;
   localparam logic [ACC_BITS-1:0] CP_Y_DIAER   = 31'h0178;
   localparam logic [ACC_BITS-1:0] CP_Z_CARON   = 31'h017D;
   localparam logic [ACC_BITS-1:0] CP_Z_CARON_L = 31'h017E;
   localparam logic [ACC_BITS-1:0] CP_EURO      = 31'h20AC;

   // One step's results: an optional data word, then an optional end word
   typedef struct packed {
      logic                  has_data;
      logic                  has_end;
      logic [BYTE_BITS-1:0]  data;
      logic [LEN_BITS-1:0]   length;
   } rec_type;

   typedef struct packed {
      logic                  ok;
      logic [BYTE_BITS-1:0]  data;
   } map_type;

   function automatic map_type latin9_map(input logic [ACC_BITS-1:0] cp);
      map_type m;
      m.ok   = 1'b1;
      m.data = cp[BYTE_BITS-1:0];
      if (cp[ACC_BITS-1:BYTE_BITS] != '0) begin
         case (cp)
            CP_OE_CAP:    m.data = 8'hBC;
            CP_OE_SMALL:  m.data = 8'hBD;
            CP_S_CARON:   m.data = 8'hA6;
            CP_S_CARON_L: m.data = 8'hA8;
            CP_Y_DIAER:   m.data = 8'hBE;
            CP_Z_CARON:   m.data = 8'hB4;
            CP_Z_CARON_L: m.data = 8'hB8;
            CP_EURO:      m.data = 8'hA4;
            default: begin
               m.ok   = 1'b0;
               m.data = '0;
            end
         endcase
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// File: rtl/u8l9_decoder.sv
// ----------------------------------------------------------------------------
// u8l9_decoder
// Sequence state, code point assembly and the saturating output count.
// ----------------------------------------------------------------------------
`default_nettype none

module u8l9_decoder #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           in_byte,
   input  wire logic                 last_byte,
   output u8l9_pkg::rec_type         rec
);
   import u8l9_pkg::*;

   logic [REM_BITS-1:0]   rem_ff,   rem_in;
   logic [ACC_BITS-1:0]   acc_ff,   acc_in;
   logic                  seqok_ff, seqok_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic                  have;
   logic [BYTE_BITS-1:0]  emit;
   logic [COUNT_BITS-1:0] count_inc;
   map_type               mapped;

   always_comb begin
      rem_in   = rem_ff;
      acc_in   = acc_ff;
      seqok_in = seqok_ff;
      have     = 1'b0;
      emit     = in_byte;
      mapped   = latin9_map({acc_ff[ACC_BITS-7:0], in_byte[5:0]});

      if (rem_ff != '0) begin
         seqok_in = seqok_ff & (in_byte[7:6] == 2'b10);
         acc_in   = {acc_ff[ACC_BITS-7:0], in_byte[5:0]};
         rem_in   = rem_ff - 1'b1;
         if (rem_in == '0 && seqok_in && mapped.ok) begin
            have = 1'b1;
            emit = mapped.data;
         end
      end else if (!in_byte[7]) begin
         have = 1'b1;
      end else if (in_byte[7:6] == 2'b11 && in_byte[7:1] != 7'h7F) begin
         seqok_in = 1'b1;
         if (!in_byte[5]) begin
            rem_in = 3'd1;
            acc_in = ACC_BITS'(in_byte[4:0]);
         end else if (!in_byte[4]) begin
            rem_in = 3'd2;
            acc_in = ACC_BITS'(in_byte[3:0]);
         end else if (!in_byte[3]) begin
            rem_in = 3'd3;
            acc_in = ACC_BITS'(in_byte[2:0]);
         end else if (!in_byte[2]) begin
            rem_in = 3'd4;
            acc_in = ACC_BITS'(in_byte[1:0]);
         end else begin
            rem_in = 3'd5;
            acc_in = ACC_BITS'(in_byte[0]);
         end
      end

      count_inc = count_ff;
      if (have && count_ff != '1) begin
         count_inc = count_ff + 1'b1;
      end
      count_in = count_inc;

      // end of string: everything back to its reset value
      if (last_byte) begin
         rem_in   = '0;
         acc_in   = '0;
         seqok_in = 1'b0;
         count_in = '0;
      end

      rec.has_data = have;
      rec.has_end  = last_byte;
      rec.data     = emit;
      rec.length   = LEN_BITS'(count_inc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= '0;
         acc_ff   <= '0;
         seqok_ff <= 1'b0;
         count_ff <= '0;
      end else if (accept) begin
         rem_ff   <= rem_in;
         acc_ff   <= acc_in;
         seqok_ff <= seqok_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/u8l9_result_buffer.sv
// ----------------------------------------------------------------------------
// u8l9_result_buffer
// Output register plus skid slot; a record yields its data word, then end word.
// ----------------------------------------------------------------------------
`default_nettype none

module u8l9_result_buffer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  u8l9_pkg::rec_type       rec,
   output logic                    space,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [23:0]             rsp_tdata,   // [7:0] out_byte, [23:8] out_length
   output logic                    rsp_tlast    // end_marker
);
   import u8l9_pkg::*;

   rec_type cur_ff,        cur_in;
   logic    cur_valid_ff,  cur_valid_in;
   rec_type skid_ff,       skid_in;
   logic    skid_valid_ff, skid_valid_in;

   logic    take;
   logic    cur_done;

   assign take     = cur_valid_ff & rsp_tready;
   assign cur_done = take & ~(cur_ff.has_data & cur_ff.has_end);
   assign space    = ~skid_valid_ff;

   always_comb begin
      cur_in        = cur_ff;
      cur_valid_in  = cur_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;

      // data word gone, end word still to send
      if (take && !cur_done) begin
         cur_in.has_data = 1'b0;
      end

      if (!cur_valid_ff || cur_done) begin
         if (skid_valid_ff) begin
            cur_in        = skid_ff;
            cur_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (push) begin
            cur_in       = rec;
            cur_valid_in = 1'b1;
         end else begin
            cur_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_in       = rec;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff  <= cur_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      cur_ff  <= cur_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = cur_valid_ff;
   assign rsp_tlast  = ~cur_ff.has_data;
   assign rsp_tdata  = {cur_ff.length, cur_ff.has_data ? cur_ff.data : 8'h00};

endmodule

`default_nettype wire

// File: rtl/utf8_to_latin9_stream_converter.sv
// Result words are registered in the output register, or in the skid slot
// while that register holds an unsent word. One byte is taken per cycle while
// the skid slot is free; a data-and-end record stays in the output register
// until both its words are out. Reset (synchronous, active high) clears the
// sequence state, the count and both result slots; no clearing pass is needed.
// ----------------------------------------------------------------------------
// utf8_to_latin9_stream_converter
// Streaming UTF-8 to ISO-8859-15 converter with terminating length word.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_latin9_stream_converter #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] in_byte
   input  wire logic        req_tlast,    // last_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,    // [7:0] out_byte, [23:8] out_length
   output logic             rsp_tlast     // end_marker
);
   import u8l9_pkg::*;

   rec_type rec;
   logic    accept;
   logic    space;

   assign req_tready = space;
   assign accept     = req_tvalid & space;

   u8l9_decoder #(
      .COUNT_BITS (COUNT_BITS)
   ) u_decoder (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_tdata),
      .last_byte (req_tlast),
      .rec       (rec)
   );

   u8l9_result_buffer u_buffer (
      .clock      (clock),
      .reset      (reset),
      .push       (accept & (rec.has_data | rec.has_end)),
      .rec        (rec),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // input only stalls behind a pending word
   a_stall_has_word : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   // a final byte always leaves a word to deliver
   a_last_gives_word : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("final byte left no result word");

   // end word carries NUL
   a_end_is_nul : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[7:0] == 8'h00)
      else $error("end word with non-zero byte");

endmodule

`default_nettype wire
